// ----- hw/rtl/aes128_block_encrypt_defines.svh -----
// ---------------------------------------------------------------------------
// aes128 block encrypt assertion macros
// shared property shorthands for the cipher pipeline
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH

// implication checked on every clock, muted during reset
`define AES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked on every clock, muted during reset
`define AES_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/aes128_pkg.sv -----
// ---------------------------------------------------------------------------
// aes128 package
// beat types, register map, sbox and round helpers
// ---------------------------------------------------------------------------
package aes128_pkg;

    localparam int unsigned NumRounds   = 10;
    localparam int unsigned AddrWidth   = 4;

    typedef enum logic [1:0] {
        REG_KEY_WORD_0 = 2'd0,
        REG_KEY_WORD_1 = 2'd1,
        REG_KEY_WORD_2 = 2'd2,
        REG_KEY_WORD_3 = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [31:0] in_word_3;
        logic [31:0] in_word_2;
        logic [31:0] in_word_1;
        logic [31:0] in_word_0;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] out_word_3;
        logic [31:0] out_word_2;
        logic [31:0] out_word_1;
        logic [31:0] out_word_0;
    } out_beat_t;

    // state and round keys: word c in [32c+31:32c], row r byte at [8r+7:8r]
    typedef logic [127:0] block_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key from the previous one
    function automatic block_t next_round_key(input block_t rk, input logic [7:0] rc);
        logic [31:0] t;
        block_t      nk;
        t = {rk[103:96], rk[127:104]};
        t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]} ^ {24'd0, rc};
        nk[31:0]   = rk[31:0] ^ t;
        nk[63:32]  = rk[63:32] ^ nk[31:0];
        nk[95:64]  = rk[95:64] ^ nk[63:32];
        nk[127:96] = rk[127:96] ^ nk[95:64];
        next_round_key = nk;
    endfunction

endpackage

// ----- hw/rtl/aes128_block_encrypt.sv -----
// ---------------------------------------------------------------------------
// aes128 block encrypt
// AES-128 ECB encryption, fully unrolled round pipeline
// ---------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  in        in    in_valid/ready     in_beat_t  (plaintext columns)
//  out       out   out_valid/ready    out_beat_t (ciphertext columns)
//  apb       in    psel/penable       key_word_0..3 at 0x0,0x4,0x8,0xc
//
//  whitening stage plus one stage per round
//  one beat per cycle sustained while the output is taken; the round stages set the depth
//  reset clears valid bits and key registers, no clearing pass
//  the whole pipe holds when the output stage is full and not taken
// ---------------------------------------------------------------------------
`include "aes128_block_encrypt_defines.svh"

module aes128_block_encrypt
    import aes128_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_beat,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [31:0] key_reg [4];
    logic        advance;
    logic        wr_en;
    logic [1:0]  reg_sel;
    logic        addr_ok;

    logic   v0_reg;
    block_t s0_reg, k0_reg;
    logic   v_q [NumRounds+1];
    block_t s_q [NumRounds+1];
    block_t k_q [NumRounds+1];

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign addr_ok = (paddr[1:0] == 2'b00);
    assign wr_en   = psel && penable && pwrite && addr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= 32'd0;
            end
        end
        else if (wr_en)
        begin
            key_reg[reg_sel] <= pwdata;
        end
    end

    always_comb
    begin
        case (reg_index_t'(reg_sel))
            REG_KEY_WORD_0: prdata = key_reg[0];
            REG_KEY_WORD_1: prdata = key_reg[1];
            REG_KEY_WORD_2: prdata = key_reg[2];
            REG_KEY_WORD_3: prdata = key_reg[3];
            default:        prdata = 32'd0;
        endcase
        if (!addr_ok)
        begin
            prdata = 32'd0;
        end
    end

    // pipe moves when last stage is empty or drains
    assign advance  = !v_q[NumRounds] || out_ready;
    assign in_ready = advance;

    // initial key whitening
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            k0_reg <= {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
            s0_reg <= block_t'(in_beat) ^ {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
        end
    end

    assign v_q[0] = v0_reg;
    assign s_q[0] = s0_reg;
    assign k_q[0] = k0_reg;

    for (genvar g = 0; g < NumRounds; g++)
    begin : g_round
        aes128_round #(
            .Rcon      (RCON[g]),
            .LastRound (g == NumRounds - 1)
        ) u_round (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .valid   (v_q[g]),
            .state   (s_q[g]),
            .rkey    (k_q[g]),
            .valid_q (v_q[g+1]),
            .state_q (s_q[g+1]),
            .rkey_q  (k_q[g+1])
        );
    end

    assign out_valid = v_q[NumRounds];
    assign out_beat  = out_beat_t'(s_q[NumRounds]);

    `AES_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat),
        "stalled result changed")
    `AES_ASSERT_IMP(a_ready_rule, 1'b1, in_ready != (out_valid && !out_ready),
        "input ready disagrees with output stall")
    `AES_ASSERT_NXT(a_drain, in_valid && in_ready, v_q[0], "accepted beat lost at entry")

endmodule

// ----- hw/rtl/aes128_round.sv -----
// ---------------------------------------------------------------------------
// aes128 round stage
// one registered cipher round plus the matching key expansion step
// ---------------------------------------------------------------------------
module aes128_round
    import aes128_pkg::*;
#(
    parameter logic [7:0] Rcon      = 8'h01,
    parameter bit         LastRound = 1'b0
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  logic   valid,
    input  block_t state,
    input  block_t rkey,
    output logic   valid_q,
    output block_t state_q,
    output block_t rkey_q
);

    logic   valid_reg;
    block_t state_reg, state_next;
    block_t rkey_reg, rkey_next;
    block_t sub_shift;
    block_t mixed;

    always_comb
    begin
        rkey_next = next_round_key(rkey, Rcon);
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sub_shift[32*c + 8*r +: 8] = SBOX[state[32*((c + r) % 4) + 8*r +: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                mixed[32*c + 8*r +: 8] =
                    gf_double(sub_shift[32*c + 8*r +: 8])
                    ^ gf_double(sub_shift[32*c + 8*((r + 1) % 4) +: 8])
                    ^ sub_shift[32*c + 8*((r + 1) % 4) +: 8]
                    ^ sub_shift[32*c + 8*((r + 2) % 4) +: 8]
                    ^ sub_shift[32*c + 8*((r + 3) % 4) +: 8];
            end
        end
        state_next = (LastRound ? sub_shift : mixed) ^ rkey_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            rkey_reg  <= rkey_next;
        end
    end

    assign valid_q = valid_reg;
    assign state_q = state_reg;
    assign rkey_q  = rkey_reg;

endmodule
